/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define IAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define IAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/iac_pkg.sv */
// ----------------------------------------------------------------------------
// iac_pkg
// Shared types, codes and sizing helpers of the integer to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package iac_pkg;

  // Default width of the converted word
  localparam int WORD_BITS_DEF = 32;

  // Conversion kinds; the unused code converts as unsigned decimal
  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  // ASCII codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LOW_A = 7'h61;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SIGN,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // capture the input word
    logic sign;         // send the minus sign
    logic dabble;       // one double dabble step
    logic emit;         // send or skip the top digit
    logic final_digit;  // the top digit is the lowest one
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic neg;  // captured word is negative signed decimal
    logic hex;  // captured word converts as hexadecimal
  } sts_t;

  // Decimal digits of the largest unsigned word of the given width
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  // Hexadecimal digits of a word of the given width
  function automatic int hex_digits(input int bits);
    return (bits + 3) / 4;
  endfunction

endpackage

`default_nettype wire

/* sv/iac_datapath.sv */
// ----------------------------------------------------------------------------
// iac_datapath
// Magnitude and digit registers, double dabble step, character output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module iac_datapath #(
  parameter int WORD_BITS = iac_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   in_value,
  input  logic [1:0]    in_kind,
  input  iac_pkg::cmd_t cmd,
  output iac_pkg::sts_t sts,
  output logic          out_strobe,
  output logic [6:0]    out_character,
  output logic          out_last
);
  import iac_pkg::*;

  localparam int DecDigits = dec_digits(WORD_BITS);
  localparam int HexDigits = hex_digits(WORD_BITS);
  localparam int DigW      = DecDigits * 4;
  localparam int HexW      = HexDigits * 4;
  localparam int HexShift  = DigW - HexW;

  logic [WORD_BITS-1:0] v_w;
  logic [WORD_BITS-1:0] mag_r, mag_nxt;
  logic [DigW-1:0]      dig_r, dig_nxt, dig_adj;
  logic                 neg_r, neg_nxt;
  logic                 hex_r, hex_nxt;
  logic                 seen_r, seen_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [6:0]           char_r, char_nxt;
  logic                 last_r, last_nxt;
  logic                 is_neg_in;
  logic [3:0]           top_dig;
  logic                 emit_ok;

  // Map one digit to its ASCII code
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    if (d >= 4'd10) begin
      return CH_LOW_A + {3'b000, d} - 7'd10;
    end
    return CH_ZERO + {3'b000, d};
  endfunction

  // Take the low word bits, zero extended when the word is wider
  assign v_w       = WORD_BITS'(in_value);
  assign is_neg_in = (in_kind == KIND_SDEC) && v_w[WORD_BITS-1];

  // Add three to every BCD digit of five or more before the shift
  for (genvar i = 0; i < DecDigits; i++) begin : g_adj
    assign dig_adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ?
                               dig_r[4*i +: 4] + 4'd3 : dig_r[4*i +: 4];
  end

  // Drop leading zeros, but always send the lowest digit
  assign top_dig = dig_r[DigW-1 -: 4];
  assign emit_ok = cmd.emit && ((top_dig != 4'd0) || seen_r || cmd.final_digit);

  // Next values of the datapath registers
  always_comb begin
    mag_nxt    = mag_r;
    dig_nxt    = dig_r;
    neg_nxt    = neg_r;
    hex_nxt    = hex_r;
    seen_nxt   = seen_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    if (cmd.load) begin
      neg_nxt  = is_neg_in;
      hex_nxt  = (in_kind == KIND_HEX);
      mag_nxt  = is_neg_in ? WORD_BITS'(~v_w + WORD_BITS'(1)) : v_w;
      dig_nxt  = (in_kind == KIND_HEX) ? (DigW'(HexW'(v_w)) << HexShift) : '0;
      seen_nxt = 1'b0;
    end
    if (cmd.sign) begin
      strobe_nxt = 1'b1;
      char_nxt   = CH_MINUS;
      last_nxt   = 1'b0;
    end
    if (cmd.dabble) begin
      dig_nxt = {dig_adj[DigW-2:0], mag_r[WORD_BITS-1]};
      mag_nxt = {mag_r[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.emit) begin
      dig_nxt = {dig_r[DigW-5:0], 4'd0};
      if (emit_ok) begin
        strobe_nxt = 1'b1;
        char_nxt   = digit_char(top_dig);
        last_nxt   = cmd.final_digit;
        seen_nxt   = 1'b1;
      end
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r    <= 1'b0;
      hex_r    <= 1'b0;
      seen_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      neg_r    <= neg_nxt;
      hex_r    <= hex_nxt;
      seen_r   <= seen_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    dig_r  <= dig_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign sts.neg       = neg_r;
  assign sts.hex       = hex_r;
  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

/* sv/iac_ctrl.sv */
// ----------------------------------------------------------------------------
// iac_ctrl
// Sequencer: setup, optional sign, double dabble steps for decimal, digit output.
// ----------------------------------------------------------------------------
`default_nettype none

module iac_ctrl #(
  parameter int WORD_BITS = iac_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  iac_pkg::sts_t sts,
  output iac_pkg::cmd_t cmd,
  output logic          busy
);
  import iac_pkg::*;

  localparam int DecDigits = dec_digits(WORD_BITS);
  localparam int HexDigits = hex_digits(WORD_BITS);
  localparam int CntW      = $clog2(WORD_BITS + 1);

  localparam logic [CntW-1:0] CntBits = CntW'(WORD_BITS);
  localparam logic [CntW-1:0] CntDec  = CntW'(DecDigits);
  localparam logic [CntW-1:0] CntHex  = CntW'(HexDigits);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) begin
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (sts.neg) begin
          state_nxt = ST_SIGN;
        end else if (sts.hex) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_CONV;
        end
      end
      ST_SIGN:  state_nxt = ST_CONV;
      ST_CONV:  if (cnt_r == CntOne) begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (cnt_r == CntOne) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Step counter: dabble steps, then digit positions
  always_comb begin
    cnt_nxt = cnt_r;
    case (state_r)
      ST_SETUP: cnt_nxt = sts.hex ? CntHex : CntBits;
      ST_SIGN:  cnt_nxt = CntBits;
      ST_CONV:  cnt_nxt = (cnt_r == CntOne) ? CntDec : cnt_r - CntOne;
      ST_EMIT:  cnt_nxt = cnt_r - CntOne;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // Commands
  always_comb begin
    cmd             = '0;
    busy            = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SETUP: ;
      ST_SIGN:  cmd.sign = 1'b1;
      ST_CONV:  cmd.dabble = 1'b1;
      ST_EMIT: begin
        cmd.emit        = 1'b1;
        cmd.final_digit = (cnt_r == CntOne);
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/integer_to_ascii_converter.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_converter
// Converts one word to ASCII text, most significant character first:
// unsigned decimal, signed decimal or lower-case hexadecimal.
// ----------------------------------------------------------------------------
//   channel  handshake            ports
//   input    start && !busy       in_value, in_kind
//   result   out_strobe           out_character, out_last
//
// An accepted word passes through a setup step, a minus sign step when
// negative, WORD_BITS double dabble steps for decimal, then one step per
// digit position (DecDigits decimal, HexDigits hex), leading zeros skipped.
// Each character appears in the cycle after its step; busy drops with the last.
// Synchronous active-low reset returns to idle; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_converter #(
  parameter int WORD_BITS = iac_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_kind,
  output logic        out_strobe,
  output logic [6:0]  out_character,
  output logic        out_last
);
  import iac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the conversion
  iac_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the word and produce characters
  iac_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_kind       (in_kind),
    .cmd           (cmd),
    .sts           (sts),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

/* sv/iac_checker.sv */
// ----------------------------------------------------------------------------
// iac_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iac_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic [6:0] out_character,
  input wire logic       out_last
);
  import iac_pkg::*;

  // An accepted word makes the block busy
  `IAC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")

  // Characters only follow a busy cycle
  `IAC_ASSERT(a_strobe_busy, out_strobe |-> $past(busy), "character while idle")

  // The minus sign is never the final character
  `IAC_ASSERT(a_minus_not_last, (out_strobe && out_character == CH_MINUS) |-> !out_last, "minus marked last")

  // A final character is followed by a gap
  `IAC_ASSERT(a_last_gap, (out_strobe && out_last) |=> !out_strobe, "character right after last")

endmodule

bind integer_to_ascii_converter iac_checker u_iac_checker (.*);

`default_nettype wire
